// ===== rtl/dafir_pkg.sv =====
package dafir_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int IDX_W     = 5;
	localparam int OUT_W     = 40;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int WIDTH_W   = 5;
	localparam int BIT_W     = 4;
	localparam int DIV_W     = 17;

	localparam logic [WIDTH_W-1:0] SW_MIN    = 5'd4;
	localparam logic [WIDTH_W-1:0] SW_MAX    = 5'd16;
	localparam logic [CFG_W-1:0]   RATIO_MAX = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATIO = 2'd0,
		CFG_WIDTH = 2'd1,
		CFG_TAPS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic               shift;
		logic               clear;
		logic               mul;
		logic               first;
		logic               drain;
		logic [BIT_W-1:0]   bit_idx;
		logic [WIDTH_W-1:0] width;
	} cell_ctrl_t;

endpackage

// ===== rtl/dafir_if.sv =====
interface dafir_in_if;
	import dafir_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic signed [SAMPLE_W-1:0] sample;
	logic [IDX_W-1:0]           coeff_index;
	logic signed [SAMPLE_W-1:0] coeff_value;

	modport source(output valid, mode, sample, coeff_index, coeff_value, input ready);
	modport sink(input valid, mode, sample, coeff_index, coeff_value, output ready);
endinterface

interface dafir_out_if;
	import dafir_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered;

	modport source(output valid, filtered, input ready);
	modport sink(input valid, filtered, output ready);
endinterface

// ===== rtl/da_decimating_fir.sv =====
// Decimating FIR built as a row of tap cells using bit-serial distributed arithmetic.
// Cell t holds delay-line entry t and coefficient t; a sample item shifts the row by one,
// a coefficient-load item (mode 1) writes one coefficient and clears the row and the
// decimation counter. A coefficient-load item, and a sample that is not due for output,
// leave the input open for the next item. A sample whose result is emitted keeps the input
// closed after it is taken, longer while the previous result has not been taken yet:
// bit-plane steps in which every cell runs one shift-add step at once (one per bit of B,
// the configured sample width), drain steps moving the cell products into the accumulator
// (one per tap in use), the one-bit-per-cycle divider by 2^B-1, and a step moving the
// quotient into the output register. The result waits in that register, so the next item
// is taken while it is still pending.
module da_decimating_fir #(
	parameter int MAX_TAPS  = 32,
	parameter int COEF_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dafir_in_if.sink                          data,
	dafir_out_if.source                       result,
	input  logic                              cfg_we,
	input  logic [dafir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dafir_pkg::CFG_W-1:0]       cfg_data
);
	import dafir_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
	localparam int TAP_CW = $clog2(MAX_TAPS + 1);
	localparam int CHI    = (1 << (COEF_BITS - 1)) - 1;
	localparam int CLO    = -CHI - 1;

	logic [CFG_W-1:0]   ratio_q;
	logic [WIDTH_W-1:0] width_q;
	logic [5:0]         taps_q;

	state_t state_q, state_d;

	logic [CFG_W-1:0]         dec_cnt_q;
	logic [BIT_W-1:0]         bidx_q;
	logic [TAP_CW-1:0]        tcnt_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_data_q;

	logic [WIDTH_W-1:0]       eff_w;
	logic [TAP_CW-1:0]        eff_taps;
	logic [CFG_W-1:0]         eff_ratio;
	logic [CFG_W-1:0]         cnt_inc;
	logic                     emit;
	logic                     accept;
	logic                     coef_we;
	logic                     div_start;
	logic                     div_done;
	logic                     out_load;
	logic signed [ACC_W-1:0]  quotient;
	logic signed [COEF_BITS-1:0] coef_sat;
	cell_ctrl_t               ctrl;

	logic signed [SAMPLE_W-1:0] smp_q  [MAX_TAPS];
	logic signed [PROD_W-1:0]   prod_q [MAX_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= CFG_W'(1);
			width_q <= SW_MAX;
			taps_q  <= 6'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RATIO: ratio_q <= cfg_data;
				CFG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				CFG_TAPS:  taps_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < SW_MIN) begin
			eff_w = SW_MIN;
		end else if (width_q > SW_MAX) begin
			eff_w = SW_MAX;
		end else begin
			eff_w = width_q;
		end
		if (taps_q == '0) begin
			eff_taps = TAP_CW'(1);
		end else if (int'(taps_q) > MAX_TAPS) begin
			eff_taps = TAP_CW'(MAX_TAPS);
		end else begin
			eff_taps = TAP_CW'(taps_q);
		end
		if (ratio_q == '0) begin
			eff_ratio = CFG_W'(1);
		end else if (ratio_q > RATIO_MAX) begin
			eff_ratio = RATIO_MAX;
		end else begin
			eff_ratio = ratio_q;
		end
	end

	always_comb begin
		if (int'(data.coeff_value) > CHI) begin
			coef_sat = COEF_BITS'(CHI);
		end else if (int'(data.coeff_value) < CLO) begin
			coef_sat = COEF_BITS'(CLO);
		end else begin
			coef_sat = COEF_BITS'(data.coeff_value);
		end
	end

	assign data.ready = (state_q == ST_IDLE);
	assign accept     = data.valid && data.ready;
	assign cnt_inc    = dec_cnt_q + CFG_W'(1);
	assign emit       = cnt_inc >= eff_ratio;
	assign acc_next   = acc_q + ACC_W'(prod_q[0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !data.mode && emit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (bidx_q == '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tcnt_q == TAP_CW'(1)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl.shift   = accept && !data.mode;
		ctrl.clear   = accept && data.mode;
		ctrl.mul     = (state_q == ST_MUL);
		ctrl.first   = (bidx_q == BIT_W'(eff_w - WIDTH_W'(1)));
		ctrl.drain   = (state_q == ST_DRAIN);
		ctrl.bit_idx = bidx_q;
		ctrl.width   = eff_w;
		coef_we      = accept && data.mode;
		div_start    = (state_q == ST_DRAIN) && (tcnt_q == TAP_CW'(1));
		out_load     = (state_q == ST_HOLD) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dec_cnt_q   <= '0;
			bidx_q      <= '0;
			tcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (data.mode || emit) begin
					dec_cnt_q <= '0;
				end else begin
					dec_cnt_q <= cnt_inc;
				end
				bidx_q <= BIT_W'(eff_w - WIDTH_W'(1));
			end else if (state_q == ST_MUL) begin
				bidx_q <= bidx_q - BIT_W'(1);
			end
			if (state_q == ST_MUL && bidx_q == '0) begin
				tcnt_q <= eff_taps;
			end else if (state_q == ST_DRAIN) begin
				tcnt_q <= tcnt_q - TAP_CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			acc_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			acc_q <= acc_next;
		end
		if (out_load) begin
			out_data_q <= OUT_W'(quotient);
		end
	end

	// products move toward cell 0 during drain, samples move away on each shift
	for (genvar t = 0; t < MAX_TAPS; t++) begin : g_cell
		logic signed [SAMPLE_W-1:0] s_in;
		logic signed [PROD_W-1:0]   p_in;
		if (t == 0) begin : g_head
			assign s_in = data.sample;
		end else begin : g_body
			assign s_in = smp_q[t-1];
		end
		if (t == MAX_TAPS - 1) begin : g_tail
			assign p_in = '0;
		end else begin : g_link
			assign p_in = prod_q[t+1];
		end
		dafir_cell #(
			.COEF_BITS(COEF_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.coef_we   (coef_we && (int'(data.coeff_index) == t)),
			.coef_wdata(coef_sat),
			.sample_in (s_in),
			.prod_in   (p_in),
			.sample_out(smp_q[t]),
			.prod_out  (prod_q[t])
		);
	end

	dafir_div #(
		.ACC_W(ACC_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc_next),
		.width   (eff_w),
		.done    (div_done),
		.quotient(quotient)
	);

	assign result.valid    = out_valid_q;
	assign result.filtered = out_data_q;

endmodule

// ===== rtl/dafir_cell.sv =====
module dafir_cell #(
	parameter int COEF_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dafir_pkg::cell_ctrl_t                ctrl,
	input  logic                                 coef_we,
	input  logic signed [COEF_BITS-1:0]          coef_wdata,
	input  logic signed [dafir_pkg::SAMPLE_W-1:0] sample_in,
	input  logic signed [COEF_BITS+dafir_pkg::SAMPLE_W-1:0] prod_in,
	output logic signed [dafir_pkg::SAMPLE_W-1:0] sample_out,
	output logic signed [COEF_BITS+dafir_pkg::SAMPLE_W-1:0] prod_out
);
	import dafir_pkg::*;

	localparam int PROD_W = COEF_BITS + SAMPLE_W;

	logic signed [SAMPLE_W-1:0]  sample_q;
	logic signed [COEF_BITS-1:0] coef_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [SAMPLE_W-1:0]  sat;
	logic                        plane_bit;
	logic signed [PROD_W-1:0]    term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctrl.clear) begin
			sample_q <= '0;
		end else if (ctrl.shift) begin
			sample_q <= sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_q <= coef_wdata;
		end
	end

	// saturate the stored sample to the configured width
	always_comb begin
		int hi_i;
		int lo_i;
		int s_i;
		hi_i = (1 << (int'(ctrl.width) - 1)) - 1;
		lo_i = -hi_i - 1;
		s_i  = int'(sample_q);
		if (s_i > hi_i) begin
			sat = SAMPLE_W'(hi_i);
		end else if (s_i < lo_i) begin
			sat = SAMPLE_W'(lo_i);
		end else begin
			sat = sample_q;
		end
	end

	assign plane_bit = sat[ctrl.bit_idx];
	assign term      = plane_bit ? PROD_W'(coef_q) : '0;

	// msb-first horner: sign plane subtracts, later planes double and add
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			if (ctrl.first) begin
				prod_q <= -term;
			end else begin
				prod_q <= (prod_q <<< 1) + term;
			end
		end else if (ctrl.drain) begin
			prod_q <= prod_in;
		end
	end

	assign sample_out = sample_q;
	assign prod_out   = prod_q;

endmodule

// ===== rtl/dafir_div.sv =====
module dafir_div #(
	parameter int ACC_W = 37
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ACC_W-1:0]             dividend,
	input  logic [dafir_pkg::WIDTH_W-1:0]       width,
	output logic                                done,
	output logic signed [ACC_W-1:0]             quotient
);
	import dafir_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             neg_q;
	logic [ACC_W-1:0] num_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   rem_sh;
	logic             fits;

	assign rem_sh = {rem_q, num_q[ACC_W-1]};
	assign fits   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ACC_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// restoring division of the magnitude, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			num_q <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
			rem_q <= '0;
			d_q   <= (DIV_W'(1) << width) - DIV_W'(1);
		end else if (cnt_q != '0) begin
			num_q <= {num_q[ACC_W-2:0], fits};
			rem_q <= fits ? DIV_W'(rem_sh - {1'b0, d_q}) : DIV_W'(rem_sh);
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'(num_q) : signed'(num_q);

endmodule

// ===== rtl/dafir_chk.sv =====
module dafir_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [dafir_pkg::OUT_W-1:0] filtered
);
	import dafir_pkg::*;

	// result waits until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(filtered))
		else $error("stalled result changed");

	// a result is loaded only from the hold state, so no result follows an item directly
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared right after an item");

	// a new result is loaded only while the input is closed
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded while input was open");

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind da_decimating_fir dafir_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (data.valid),
	.in_ready (data.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.filtered (result.filtered)
);

// ===== bench/da_decimating_fir_checker.sv =====
module da_decimating_fir_checker #(
	parameter int TAP_SLOTS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	dafir_in_if                             data,
	dafir_out_if                            result,
	input  logic                            cfg_we,
	input  logic [dafir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dafir_pkg::CFG_W-1:0]     cfg_data,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dafir_pkg::*;

	logic signed [SAMPLE_W-1:0] history [TAP_SLOTS];
	logic signed [SAMPLE_W-1:0] coef [TAP_SLOTS];
	logic [CFG_W-1:0]           ratio_r;
	logic [WIDTH_W-1:0]         width_r;
	logic [5:0]                 taps_r;
	int unsigned                decim_count;
	int unsigned                decim_due;
	int                         errors;
	logic signed [OUT_W-1:0]    pending_filtered [$];
	logic signed [OUT_W-1:0]    want;

	// exact sum of coefficient times saturated sample, scaled by 1/(2^B-1)
	function automatic logic signed [OUT_W-1:0] filter_value();
		int unsigned bits;
		int unsigned used;
		int          t;
		longint      acc;
		longint      hi;
		longint      s;
		longint      divisor;
		bits = (width_r < SW_MIN) ? SW_MIN : (width_r > SW_MAX) ? SW_MAX : width_r;
		used = (taps_r == 0) ? 1 : (taps_r > TAP_SLOTS) ? TAP_SLOTS : taps_r;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		acc = 0;
		for (t = 0; t < used; t++) begin
			s = history[t];
			if (s > hi)
				s = hi;
			else if (s < -hi - 1)
				s = -hi - 1;
			acc += s * longint'(coef[t]);
		end
		divisor = (longint'(1) <<< bits) - 1;
		return OUT_W'(acc / divisor);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_r = 9'd1;
			width_r = 5'd16;
			taps_r = 6'd1;
			decim_count = 0;
			errors = 0;
			pending_filtered.delete();
			for (int i = 0; i < TAP_SLOTS; i++)
				history[i] = '0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_filtered.size() == 0) begin
					if (errors < 10)
						$display("%0t: result %0d arrived with nothing expected",
							$realtime, result.filtered);
					errors++;
				end else begin
					want = pending_filtered.pop_front();
					if (result.filtered !== want) begin
						if (errors < 10)
							$display("%0t: filtered mismatch, expected %0d got %0d",
								$realtime, want, result.filtered);
						errors++;
					end
				end
			end
			if (data.valid && data.ready) begin
				if (data.mode) begin
					// coefficient is already 16 bits, so saturation to COEF_BITS is a no-op
					coef[data.coeff_index] = data.coeff_value;
					for (int i = 0; i < TAP_SLOTS; i++)
						history[i] = '0;
					decim_count = 0;
				end else begin
					for (int i = TAP_SLOTS - 1; i > 0; i--)
						history[i] = history[i-1];
					history[0] = data.sample;
					decim_due = (ratio_r == 0) ? 1 : (ratio_r > RATIO_MAX) ? RATIO_MAX : ratio_r;
					decim_count++;
					// ratio may have been lowered below the running count
					if (decim_count >= decim_due) begin
						pending_filtered.push_back(filter_value());
						decim_count = 0;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_RATIO: ratio_r = cfg_data[8:0];
					CFG_WIDTH: width_r = cfg_data[4:0];
					CFG_TAPS:  taps_r = cfg_data[5:0];
					default: ;
				endcase
			end
		end
		fail_count <= errors;
		pending <= pending_filtered.size();
	end

endmodule

// ===== bench/da_decimating_fir_test.sv =====
module da_decimating_fir_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dafir_pkg::*;

	localparam int TAP_SLOTS    = 32;
	localparam int SETTLE       = 128;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 970;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fails;
	int                   pending;

	logic valid_high = 1'b0;
	int   burst_left = 0;
	int   items_sent = 0;
	int   idle_cycles = 0;
	int   ready_pattern = 0;
	int   pattern_left = 0;
	logic [4:0] stall_ctr = '0;

	dafir_in_if  data_ch();
	dafir_out_if res_ch();

	da_decimating_fir #(
		.MAX_TAPS(TAP_SLOTS),
		.COEF_BITS(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.data(data_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	da_decimating_fir_checker #(
		.TAP_SLOTS(TAP_SLOTS)
	) fir_check (
		.clk(clk),
		.arst_n(arst_n),
		.data(data_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fails),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure, switching between patterns now and then
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			ready_pattern <= $urandom_range(0, 3);
			pattern_left <= $urandom_range(50, 400);
		end else begin
			pattern_left <= pattern_left - 1;
		end
		case (ready_pattern)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 2) != 0);
			2: res_ch.ready <= (stall_ctr[4:3] == 2'b00);
			default: res_ch.ready <= stall_ctr[0];
		endcase
		stall_ctr <= stall_ctr + 5'd1;
	end

	always @(posedge clk) begin
		if (!arst_n || (data_ch.valid && data_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("da_decimating_fir regression: fail");
			$finish;
		end
	end

	task automatic send_item(input logic m, input logic [15:0] smp, input logic [4:0] idx,
		input logic [15:0] cv);
		int gap;
		data_ch.valid <= 1'b1;
		data_ch.mode <= m;
		data_ch.sample <= smp;
		data_ch.coeff_index <= idx;
		data_ch.coeff_value <= cv;
		valid_high = 1'b1;
		@(posedge clk);
		while (!data_ch.ready)
			@(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 :
				($urandom_range(0, 9) == 0) ? $urandom_range(10, 100) : $urandom_range(1, 9);
			if (gap > 0) begin
				data_ch.valid <= 1'b0;
				valid_high = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every result is out and the block has gone quiet
	task automatic wait_drained();
		if (valid_high) begin
			data_ch.valid <= 1'b0;
			valid_high = 1'b0;
		end
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [8:0] ratio, input logic [4:0] width,
		input logic [5:0] taps);
		logic [3:0] junk_w;
		logic [2:0] junk_t;
		junk_w = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
		junk_t = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0;
		if ($urandom_range(0, 7) == 0)
			write_reg(CFG_UNUSED, 9'($urandom));
		write_reg(CFG_RATIO, ratio);
		write_reg(CFG_WIDTH, {junk_w, width});
		write_reg(CFG_TAPS, {junk_t, taps});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3, 4: return 16'($urandom_range(0, 63)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// every coefficient at one extreme and every sample at one extreme
	task automatic full_scale_phase();
		logic [15:0] c_ext;
		logic [15:0] s_ext;
		int          n;
		c_ext = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
		s_ext = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
		wait_drained();
		configure(9'd1, 5'd16, 6'd32);
		for (n = 0; n < TAP_SLOTS; n++)
			send_item(MODE_COEF, 16'($urandom), 5'(n), c_ext);
		for (n = 0; n < 40; n++)
			send_item(MODE_SAMPLE, s_ext, 5'($urandom), 16'($urandom));
	endtask

	task automatic random_phase();
		logic [8:0] ratio;
		logic [4:0] width;
		logic [5:0] taps;
		int         due;
		int         len;
		int         n;
		case ($urandom_range(0, 24))
			0: ratio = 9'($urandom);
			1, 2: ratio = 9'($urandom_range(5, 40));
			3: ratio = 9'd0;
			default: ratio = 9'($urandom_range(1, 4));
		endcase
		width = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(4, 16));
		taps = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
		due = (ratio == 0) ? 1 : (ratio > RATIO_MAX) ? RATIO_MAX : ratio;
		if (due > 40)
			len = due + $urandom_range(1, due - 1);
		else if (due > 4)
			len = due * $urandom_range(1, 3) + $urandom_range(0, due - 1);
		else
			len = $urandom_range(20, 60);
		wait_drained();
		configure(ratio, width, taps);
		for (n = 0; n < len; n++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(MODE_COEF, 16'($urandom), 5'($urandom), pick_coef());
			else
				send_item(MODE_SAMPLE, pick_sample(), 5'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int n;
		int start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_RATIO;
		cfg_data <= '0;
		data_ch.valid <= 1'b0;
		data_ch.mode <= MODE_SAMPLE;
		data_ch.sample <= '0;
		data_ch.coeff_index <= '0;
		data_ch.coeff_value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every coefficient gets written before any tap is read
		for (n = 0; n < TAP_SLOTS; n++)
			send_item(MODE_COEF, 16'($urandom), 5'(n),
				(n == 0) ? 16'h8000 : (n == 1) ? 16'h7fff : (n == 2) ? 16'h0000 :
				(n == 3) ? 16'hffff : 16'($urandom));

		wait_drained();
		configure(9'd1, 5'd16, 6'd32);
		send_item(MODE_SAMPLE, 16'h7fff, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h8000, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h0000, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'hffff, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h0001, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h5555, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'haaaa, 5'd0, 16'd0);

		// narrow width, so samples just outside its range saturate
		wait_drained();
		configure(9'd1, 5'd4, 6'd3);
		send_item(MODE_SAMPLE, 16'h0007, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h0008, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'hfff8, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'hfff7, 5'd0, 16'd0);

		// zero in every register acts as its minimum
		wait_drained();
		configure(9'd0, 5'd0, 6'd0);
		send_item(MODE_SAMPLE, 16'h7fff, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h8000, 5'd0, 16'd0);

		// width and taps above range act as the maximum, ratio left mid-count
		wait_drained();
		configure(9'd5, 5'd31, 6'd63);
		for (n = 0; n < 4; n++)
			send_item(MODE_SAMPLE, pick_sample(), 5'd0, 16'd0);

		// ratio dropped below the running count
		wait_drained();
		write_reg(CFG_UNUSED, 9'h1ff);
		write_reg(CFG_RATIO, 9'd2);
		cfg_we <= 1'b0;
		send_item(MODE_SAMPLE, 16'h1234, 5'd0, 16'd0);

		// coefficient load clears the counter and the delay line
		send_item(MODE_SAMPLE, 16'h4321, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h0f0f, 5'd0, 16'd0);
		send_item(MODE_COEF, 16'h7fff, 5'd5, 16'h3000);
		send_item(MODE_SAMPLE, 16'hc000, 5'd0, 16'd0);
		send_item(MODE_SAMPLE, 16'h2000, 5'd0, 16'd0);

		start = items_sent;
		full_scale_phase();
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				full_scale_phase();
			else
				random_phase();
		end

		wait_drained();
		if (fails == 0 && pending == 0)
			$display("da_decimating_fir regression: pass");
		else
			$display("da_decimating_fir regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/dafir_pkg.sv
rtl/dafir_if.sv
rtl/dafir_cell.sv
rtl/dafir_div.sv
rtl/da_decimating_fir.sv
rtl/dafir_chk.sv
bench/da_decimating_fir_checker.sv
bench/da_decimating_fir_test.sv
